/* rtl/core/configurable_crc_byte_engine_top_macros.svh */
// assertion helpers shared by the crc engine rtl
`ifndef CONFIGURABLE_CRC_BYTE_ENGINE_TOP_MACROS_SVH
`define CONFIGURABLE_CRC_BYTE_ENGINE_TOP_MACROS_SVH

// same-cycle implication, masked while in reset
`define CRCE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked while in reset
`define CRCE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/crce_pkg.sv */
package crce_pkg;

    localparam int unsigned CRC_W     = 32;
    localparam int unsigned DATA_W    = 8;
    localparam int unsigned CFG_IDX_W = 3;

    typedef logic [1:0] t_width_mode;

    localparam t_width_mode WMODE_8  = 2'd0;
    localparam t_width_mode WMODE_16 = 2'd1;
    localparam t_width_mode WMODE_32 = 2'd2;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POLYNOMIAL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_VALUE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REFLECT_IN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REFLECT_OUT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FINAL_XOR   = 3'd5;

    // reset defaults: crc-16/x.25
    localparam t_width_mode       RST_WIDTH_MODE = WMODE_16;
    localparam logic [CRC_W-1:0]  RST_POLYNOMIAL = 32'h0000_1021;
    localparam logic [CRC_W-1:0]  RST_INIT_VALUE = 32'h0000_FFFF;
    localparam logic [CRC_W-1:0]  RST_FINAL_XOR  = 32'h0000_FFFF;

    typedef struct packed {
        t_width_mode      width_mode;
        logic [CRC_W-1:0] polynomial;
        logic [CRC_W-1:0] init_value;
        logic             reflect_input;
        logic             reflect_output;
        logic [CRC_W-1:0] final_xor;
    } t_cfg;

    function automatic logic [DATA_W-1:0] reverse_byte(input logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] r;
        for (int i = 0; i < DATA_W; i++) begin
            r[i] = v[DATA_W-1-i];
        end
        return r;
    endfunction

    function automatic logic [CRC_W-1:0] reverse_word(input logic [CRC_W-1:0] v);
        logic [CRC_W-1:0] r;
        for (int i = 0; i < CRC_W; i++) begin
            r[i] = v[CRC_W-1-i];
        end
        return r;
    endfunction

    // move a width-sized value up to the top of the 32-bit word, dropping bits above the width
    function automatic logic [CRC_W-1:0] left_justify(input logic [CRC_W-1:0] v,
                                                      input t_width_mode m);
        logic [CRC_W-1:0] r;
        case (m)
            WMODE_8:  r = v << 24;
            WMODE_16: r = v << 16;
            default:  r = v;
        endcase
        return r;
    endfunction

    function automatic logic [CRC_W-1:0] right_justify(input logic [CRC_W-1:0] v,
                                                       input t_width_mode m);
        logic [CRC_W-1:0] r;
        case (m)
            WMODE_8:  r = v >> 24;
            WMODE_16: r = v >> 16;
            default:  r = v;
        endcase
        return r;
    endfunction

endpackage

/* rtl/core/crce_cfg_regs.sv */
module crce_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_wr_en,
    input  logic [crce_pkg::CFG_IDX_W-1:0]  i_wr_index,
    input  logic [crce_pkg::CRC_W-1:0]      i_wr_data,
    output crce_pkg::t_cfg                  o_cfg
);
    import crce_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            unique case (i_wr_index)
                REG_WIDTH_MODE:  n_cfg.width_mode     = i_wr_data[1:0];
                REG_POLYNOMIAL:  n_cfg.polynomial     = i_wr_data;
                REG_INIT_VALUE:  n_cfg.init_value     = i_wr_data;
                REG_REFLECT_IN:  n_cfg.reflect_input  = i_wr_data[0];
                REG_REFLECT_OUT: n_cfg.reflect_output = i_wr_data[0];
                REG_FINAL_XOR:   n_cfg.final_xor      = i_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width_mode     <= RST_WIDTH_MODE;
            r_cfg.polynomial     <= RST_POLYNOMIAL;
            r_cfg.init_value     <= RST_INIT_VALUE;
            r_cfg.reflect_input  <= 1'b1;
            r_cfg.reflect_output <= 1'b1;
            r_cfg.final_xor      <= RST_FINAL_XOR;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/core/crce_byte_step.sv */
module crce_byte_step (
    input  crce_pkg::t_cfg                  i_cfg,
    input  logic                            i_start,
    input  logic [crce_pkg::CRC_W-1:0]      i_crc,
    input  logic [crce_pkg::DATA_W-1:0]     i_byte,
    output logic [crce_pkg::CRC_W-1:0]      o_crc_next,
    output logic [crce_pkg::CRC_W-1:0]      o_crc_final
);
    import crce_pkg::*;

    logic [CRC_W-1:0]  base;
    logic [CRC_W-1:0]  poly_l;
    logic [CRC_W-1:0]  reg_l;
    logic [CRC_W-1:0]  mask;
    logic [CRC_W-1:0]  refl;
    logic [DATA_W-1:0] in_byte;

    // work left-justified so the top bit is always bit 31 whatever the width
    always_comb begin
        base    = i_start ? i_cfg.init_value : i_crc;
        poly_l  = left_justify(i_cfg.polynomial, i_cfg.width_mode);
        in_byte = i_cfg.reflect_input ? reverse_byte(i_byte) : i_byte;
        reg_l   = left_justify(base, i_cfg.width_mode)
                  ^ {in_byte, {(CRC_W-DATA_W){1'b0}}};
        for (int i = 0; i < DATA_W; i++) begin
            if (reg_l[CRC_W-1]) begin
                reg_l = (reg_l << 1) ^ poly_l;
            end else begin
                reg_l = reg_l << 1;
            end
        end
        mask        = right_justify({CRC_W{1'b1}}, i_cfg.width_mode);
        o_crc_next  = right_justify(reg_l, i_cfg.width_mode);
        // full-word reversal of the justified value is the reversal over the width
        refl        = i_cfg.reflect_output ? reverse_word(reg_l) : o_crc_next;
        o_crc_final = (refl ^ i_cfg.final_xor) & mask;
    end

endmodule

/* rtl/core/configurable_crc_byte_engine_top.sv */
// configurable byte-serial crc engine, msb-first shift register
//
// input stream: one message byte per word on i_s_tdata, i_s_tlast marks the
// final byte of a message. output stream: one word per message carrying the
// finished crc on o_m_tdata, bits above the selected width read as zero.
// configuration channel: index/data writes to six registers (width mode,
// polynomial, init value, input and output reflection, final xor); it is
// always ready and should only be written while no message is in flight.
//
// timing: a byte is registered in the input register on acceptance, then
// folded into the crc, and a last byte also into the result register that
// drives o_m_tvalid. throughput is one byte per cycle while no last byte
// waits on a full result register, through the single eight-step shift-xor
// network between the input register and the crc and result registers.
//
// reset: registers return to crc-16/x.25 defaults, all stages empty.
// when the receiver stalls, the result register holds; non-last bytes keep
// flowing, and a last byte waits in the input register, holding o_s_tready
// low, until the result is taken.
`include "configurable_crc_byte_engine_top_macros.svh"

module configurable_crc_byte_engine_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // message byte stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [crce_pkg::DATA_W-1:0]     i_s_tdata,   // [7:0] data_byte
    input  logic                            i_s_tlast,   // last_byte
    // crc result stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [crce_pkg::CRC_W-1:0]      o_m_tdata,   // [31:0] crc_value
    // configuration writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [crce_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [crce_pkg::CRC_W-1:0]      i_cfg_data
);
    import crce_pkg::*;

    t_cfg cfg;

    // input register
    logic              r_in_valid;
    logic [DATA_W-1:0] r_in_byte;
    logic              r_in_last;
    // running crc state
    logic              r_in_msg;
    logic [CRC_W-1:0]  r_crc;
    // result register
    logic              r_out_valid;
    logic [CRC_W-1:0]  r_out_crc;

    logic              s_accept;
    logic              out_free;
    logic              advance;
    logic [CRC_W-1:0]  crc_next;
    logic [CRC_W-1:0]  crc_final;

    assign o_cfg_ready = 1'b1;

    crce_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    crce_byte_step u_step (
        .i_cfg       (cfg),
        .i_start     (!r_in_msg),
        .i_crc       (r_crc),
        .i_byte      (r_in_byte),
        .o_crc_next  (crc_next),
        .o_crc_final (crc_final)
    );

    // result slot is free if empty or being drained this cycle
    assign out_free   = !r_out_valid || i_m_tready;
    // non-last bytes never need the result slot
    assign advance    = r_in_valid && (!r_in_last || out_free);
    assign o_s_tready = !r_in_valid || advance;
    assign s_accept   = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_in_msg    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_in_msg <= !r_in_last;
            end
            if (advance && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload, qualified by the control bits above
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
        if (advance) begin
            r_crc <= crc_next;
        end
        if (advance && r_in_last) begin
            r_out_crc <= crc_final;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_crc;

    `CRCE_ASSERT_NEXT(a_last_gives_result, i_clk, i_rst_n, advance && r_in_last,
        r_out_valid, "last byte processed without a result")
    `CRCE_ASSERT_NEXT(a_last_ends_message, i_clk, i_rst_n, advance && r_in_last,
        !r_in_msg, "message still open after last byte")
    `CRCE_ASSERT_NEXT(a_byte_opens_message, i_clk, i_rst_n, advance && !r_in_last,
        r_in_msg, "message not open after a middle byte")
    `CRCE_ASSERT_NEXT(a_held_byte_kept, i_clk, i_rst_n, r_in_valid && !advance,
        r_in_valid && $stable(r_in_byte) && $stable(r_in_last), "held byte lost")

endmodule

/* verif/configurable_crc_byte_engine_top_tb.sv */
module configurable_crc_byte_engine_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import crce_pkg::*;

    // one message byte waiting to go onto the input stream
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              last;
    } t_msg_byte;

    localparam int unsigned CYCLE_LIMIT     = 200_000;
    localparam int unsigned SETTLE_CYCLES   = 4;
    localparam int unsigned HOLD_CYCLES     = 400;   // long receiver back-pressure
    localparam int unsigned BYTES_PER_PHASE = 200;
    localparam int unsigned NUM_PHASES      = 6;

    // indexes past the end of the register file, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    // width code with no meaning of its own, acts as 32 bits
    localparam t_width_mode WMODE_SPARE = 2'd3;

    // dut ports, all inputs driven to known values from time zero
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [DATA_W-1:0]    i_s_tdata   = '0;
    logic                 i_s_tlast   = 1'b0;
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic [CRC_W-1:0]     o_m_tdata;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CRC_W-1:0]     i_cfg_data  = '0;

    // stimulus and expected crc words
    t_msg_byte        byte_queue[$];
    logic [CRC_W-1:0] crc_expected[$];
    t_msg_byte        next_byte;
    logic [CRC_W-1:0] crc_want;

    // shadow of the engine: its registers, running crc and message flag
    t_cfg             cfg_shadow;
    logic [CRC_W-1:0] crc_acc;
    logic             msg_open;

    // idling and back-pressure control
    int unsigned snd_idle_pct = 22;
    int unsigned rcv_idle_pct = 45;
    int unsigned hold_req     = 0;
    int unsigned hold_seen    = 0;
    int unsigned hold_left    = 0;

    int unsigned cycle_count = 0;
    int unsigned err_count   = 0;
    int unsigned bytes_sent  = 0;
    int unsigned crc_checked = 0;
    int unsigned cfg_writes  = 0;

    configurable_crc_byte_engine_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),   // [7:0] data_byte
        .i_s_tlast   (i_s_tlast),   // last_byte
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),   // [31:0] crc_value
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // reverse the low n bits of v
    function automatic logic [CRC_W-1:0] mirror_bits(input logic [CRC_W-1:0] v,
                                                     input int unsigned n);
        logic [CRC_W-1:0] r;
        r = '0;
        for (int unsigned i = 0; i < n; i++) begin
            r = {r[CRC_W-2:0], v[i]};
        end
        return r;
    endfunction

    // fold one accepted byte into the shadow crc, queue the finished word on a last byte
    function automatic void fold_byte(input logic [DATA_W-1:0] b_in, input logic last);
        int unsigned      nbits;
        logic [CRC_W-1:0] mask;
        logic [CRC_W-1:0] top;
        logic [CRC_W-1:0] poly;
        logic [CRC_W-1:0] acc;
        logic [CRC_W-1:0] b;
        nbits = (cfg_shadow.width_mode == WMODE_8)  ? 8 :
                (cfg_shadow.width_mode == WMODE_16) ? 16 : 32;
        mask  = (nbits == 32) ? 32'hFFFF_FFFF : ((32'd1 << nbits) - 32'd1);
        top   = 32'd1 << (nbits - 1);
        poly  = cfg_shadow.polynomial & mask;
        // a new message starts from the init value
        if (!msg_open) begin
            crc_acc  = cfg_shadow.init_value;
            msg_open = 1'b1;
        end
        acc = crc_acc & mask;
        b   = {24'd0, b_in};
        if (cfg_shadow.reflect_input) begin
            b = mirror_bits(b, 8);
        end
        acc ^= b << (nbits - 8);
        for (int i = 0; i < 8; i++) begin
            acc = (acc & top) ? ((acc << 1) ^ poly) : (acc << 1);
            acc &= mask;
        end
        crc_acc = acc;
        if (last) begin
            if (cfg_shadow.reflect_output) begin
                acc = mirror_bits(acc, nbits);
            end
            crc_expected.push_back((acc ^ cfg_shadow.final_xor) & mask);
            crc_acc  = cfg_shadow.init_value & mask;
            msg_open = 1'b0;
        end
    endfunction

    // one write on the configuration channel, shadow updated once it is taken
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CRC_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_WIDTH_MODE:  cfg_shadow.width_mode     = val[1:0];
            REG_POLYNOMIAL:  cfg_shadow.polynomial     = val;
            REG_INIT_VALUE:  cfg_shadow.init_value     = val;
            REG_REFLECT_IN:  cfg_shadow.reflect_input  = val[0];
            REG_REFLECT_OUT: cfg_shadow.reflect_output = val[0];
            REG_FINAL_XOR:   cfg_shadow.final_xor      = val;
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic push_byte(input logic [DATA_W-1:0] data, input logic last);
        t_msg_byte mb;
        mb.data = data;
        mb.last = last;
        byte_queue.push_back(mb);
    endtask

    // wait for every byte to be taken and every crc word to come back,
    // then let the pipeline settle since non-last bytes give nothing to wait on
    task automatic drain_all;
        while (byte_queue.size() != 0 || i_s_tvalid || crc_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // input driver: present the next byte when the slot is free, with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                fold_byte(i_s_tdata, i_s_tlast);
                bytes_sent++;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (byte_queue.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
                    next_byte = byte_queue.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= next_byte.data;
                    i_s_tlast  <= next_byte.last;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor: check each crc word against the oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (crc_expected.size() == 0) begin
                    $display("%0t: crc word with none expected, expected none actual %08h",
                             $time, o_m_tdata);
                    err_count++;
                end else begin
                    crc_want = crc_expected.pop_front();
                    if (o_m_tdata !== crc_want) begin
                        $display("%0t: crc_value mismatch, expected %08h actual %08h",
                                 $time, crc_want, o_m_tdata);
                        err_count++;
                    end
                    crc_checked++;
                end
            end
            i_m_tready <= (hold_left == 0) && ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // long receiver hold-off, counted here so the sender carries on meanwhile
    always @(posedge i_clk) begin
        if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // stimulus sequence
    initial begin
        t_width_mode      wmode;
        logic [CRC_W-1:0] wdata;
        logic [CRC_W-1:0] rin;
        logic [CRC_W-1:0] rout;
        int unsigned      filled;
        int unsigned      len;

        // shadow starts at the crc-16/x.25 defaults
        cfg_shadow.width_mode     = RST_WIDTH_MODE;
        cfg_shadow.polynomial     = RST_POLYNOMIAL;
        cfg_shadow.init_value     = RST_INIT_VALUE;
        cfg_shadow.reflect_input  = 1'b1;
        cfg_shadow.reflect_output = 1'b1;
        cfg_shadow.final_xor      = RST_FINAL_XOR;
        crc_acc  = RST_INIT_VALUE;
        msg_open = 1'b0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults on the usual check string, then single-byte extremes
        for (int i = 0; i < 9; i++) begin
            push_byte(8'(8'h31 + i), i == 8);
        end
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);
        drain_all();

        // plain crc-8, no reflection, zero init and xor
        write_reg(REG_WIDTH_MODE, {30'd0, WMODE_8});
        write_reg(REG_POLYNOMIAL, 32'h0000_0007);
        write_reg(REG_INIT_VALUE, 32'h0000_0000);
        write_reg(REG_REFLECT_IN, 32'h0000_0000);
        write_reg(REG_REFLECT_OUT, 32'h0000_0000);
        write_reg(REG_FINAL_XOR, 32'h0000_0000);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hA5, 1'b1);
        drain_all();

        // 32-bit generator via the spare width code, upper data bits set on the flags
        write_reg(REG_WIDTH_MODE, {30'h3FFF_FFFF, WMODE_SPARE});
        write_reg(REG_POLYNOMIAL, 32'h04C1_17DB);
        write_reg(REG_INIT_VALUE, 32'hFFFF_FFFF);
        write_reg(REG_REFLECT_IN, 32'hFFFF_FFFF);
        write_reg(REG_REFLECT_OUT, 32'h8000_0001);
        write_reg(REG_FINAL_XOR, 32'hFFFF_FFFF);
        push_byte(8'h5A, 1'b0);
        push_byte(8'h80, 1'b1);
        push_byte(8'h01, 1'b1);
        drain_all();

        // narrow the width and move the init value part-way through a message:
        // high register bits are lost, the new init only counts from the next message
        push_byte(8'h3C, 1'b0);
        push_byte(8'h96, 1'b0);
        drain_all();
        write_reg(REG_WIDTH_MODE, {30'd0, WMODE_16});
        write_reg(REG_INIT_VALUE, 32'h1234_5678);
        push_byte(8'hC3, 1'b1);
        push_byte(8'h7E, 1'b1);
        drain_all();

        // writes beyond the register file change nothing
        write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_HI, 32'h0000_0000);
        push_byte(8'h11, 1'b1);
        drain_all();

        // random phases: one register setting each, idling pattern per pair of phases
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0, 5:    wmode = WMODE_8;
                1:       wmode = WMODE_16;
                3:       wmode = WMODE_SPARE;
                default: wmode = WMODE_32;
            endcase
            wdata      = $urandom;
            wdata[1:0] = wmode;
            write_reg(REG_WIDTH_MODE, wdata);
            rin  = $urandom;
            rout = $urandom;
            if (phase == 4) begin
                // everything at its top value
                write_reg(REG_POLYNOMIAL, 32'hFFFF_FFFF);
                write_reg(REG_INIT_VALUE, 32'hFFFF_FFFF);
                write_reg(REG_FINAL_XOR, 32'hFFFF_FFFF);
                rin[0]  = 1'b1;
                rout[0] = 1'b1;
            end else if (phase == 5) begin
                // everything at zero
                write_reg(REG_POLYNOMIAL, 32'h0000_0000);
                write_reg(REG_INIT_VALUE, 32'h0000_0000);
                write_reg(REG_FINAL_XOR, 32'h0000_0000);
                rin[0]  = 1'b0;
                rout[0] = 1'b0;
            end else begin
                write_reg(REG_POLYNOMIAL, $urandom);
                write_reg(REG_INIT_VALUE, $urandom);
                write_reg(REG_FINAL_XOR, $urandom);
            end
            write_reg(REG_REFLECT_IN, rin);
            write_reg(REG_REFLECT_OUT, rout);

            if (phase < 2) begin
                snd_idle_pct <= 22;
                rcv_idle_pct <= 45;
            end else if (phase < 4) begin
                snd_idle_pct <= 45;
                rcv_idle_pct <= 22;
            end else begin
                snd_idle_pct <= 0;
                rcv_idle_pct <= 0;
            end

            // mostly short messages, now and then a long one
            filled = 0;
            while (filled < BYTES_PER_PHASE) begin
                len = ($urandom_range(7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
                for (int unsigned j = 0; j < len; j++) begin
                    push_byte(8'($urandom), j == len - 1);
                end
                filled += len;
            end

            // back-pressure with the sender flat out, so the input stalls
            if (phase == 4) begin
                hold_req <= hold_req + 1;
            end
            drain_all();
        end

        repeat (8) @(posedge i_clk);
        $display("covered %0d message bytes and %0d crc words over %0d register writes",
                 bytes_sent, crc_checked, cfg_writes);
        $display("widths 8, 16, 32 and the spare code, both reflections, mid-message changes");
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/crce_pkg.sv
rtl/core/crce_cfg_regs.sv
rtl/core/crce_byte_step.sv
rtl/core/configurable_crc_byte_engine_top.sv
verif/configurable_crc_byte_engine_top_tb.sv
